[rtl/core/two_stack_selection_sorter_top_defines.svh]
// Assertion macros used by the sorter's top-level RTL file.
// Each macro expects clk and rst in scope where it is used.
`ifndef TWO_STACK_SELECTION_SORTER_TOP_DEFINES_SVH
`define TWO_STACK_SELECTION_SORTER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tss_pkg.sv]
// Types and constants shared by the two-stack selection sorter.
// No dependencies; the top, controller and datapath files import this package.
package tss_pkg;

  localparam int DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample_value;
    logic                     load_last;
  } load_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     sorted_last;
  } sort_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_wr;   // write the incoming value into the source area
    logic scan_rd;   // read the source area during a scan
    logic proc;      // read data is valid this cycle
    logic first;     // the valid read data is the first of the pass
    logic load_out;  // move the pass minimum into the output register
    logic out_last;  // the minimum being moved is the final one
    logic sel;       // 0: area A is the source, 1: area B is the source
  } ctl_cmd_t;

endpackage

[rtl/core/two_stack_selection_sorter_top.sv]
// Channel   Payload      Handshake
// load      load_item    load_valid / load_stall  (values in, last marks end of set)
// sort      sort_item    sort_valid / sort_stall  (ascending values, last marked)
//
// Loading takes one item per cycle until the item marked last.
// Sorting n stored values runs n passes; each pass scans the source area through
// its RAM's read port and then hands its minimum to the output register.
// load_stall stays high meanwhile.
// Reset is synchronous; there is no clearing pass, the store starts empty.
// A stalled output holds the next pass at its emit step until the item is taken.
// Top level of the sorter; depends on tss_pkg, tss_ctrl, tss_dpath and the defines header.
`include "two_stack_selection_sorter_top_defines.svh"

module two_stack_selection_sorter_top import tss_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       load_valid,
  output logic       load_stall,
  input  load_item_t load_item,
  output logic       sort_valid,
  input  logic       sort_stall,
  output sort_item_t sort_item
);

  localparam int AW = $clog2(CAPACITY);

  ctl_cmd_t          cmd;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              out_free;
  logic              busy;

  tss_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .load_valid (load_valid),
    .load_last  (load_item.load_last),
    .out_free   (out_free),
    .cmd        (cmd),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .busy       (busy)
  );

  tss_dpath #(.CAPACITY(CAPACITY)) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .load_value (load_item.sample_value),
    .out_stall  (sort_stall),
    .out_free   (out_free),
    .out_valid  (sort_valid),
    .out_item   (sort_item)
  );

  assign load_stall = busy;

  // Tracks the previous emitted value of the current run for the order check.
  logic signed [DATA_W-1:0] prev_value;
  logic                     run_open;
  logic                     last_fire;
  logic                     order_ok;
  logic                     cmd_clash;

  assign last_fire = load_valid && !load_stall && load_item.load_last;
  assign order_ok  = sort_item.sorted_value >= prev_value;
  assign cmd_clash = cmd.load_wr && (cmd.scan_rd || cmd.proc || cmd.load_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open <= 1'b0;
    end else if (sort_valid && !sort_stall) begin
      run_open <= !sort_item.sorted_last;
    end
    if (sort_valid && !sort_stall) begin
      prev_value <= sort_item.sorted_value;
    end
  end

  `TSS_ASSERT_NXT(a_busy_after_last, last_fire, load_stall, "input open after last item")
  `TSS_ASSERT_IMP(a_ascending, sort_valid && run_open, order_ok, "sorted items out of order")
  `TSS_ASSERT_IMP(a_one_cmd, 1'b1, !cmd_clash, "load write overlaps sort activity")

endmodule

[rtl/core/tss_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/tss_ctrl.sv]
// Controller of the sorter: load, scan and emit sequencing with all counters.
// Depends on tss_pkg for the command struct.
module tss_ctrl import tss_pkg::*; #(
  parameter int CAPACITY = 64,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load_valid,
  input  logic          load_last,
  input  logic          out_free,
  output ctl_cmd_t      cmd,
  output logic [AW-1:0] wr_addr,
  output logic [AW-1:0] rd_addr,
  output logic          busy
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t        state;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic [CW-1:0] issue;
  logic [CW-1:0] issue_m1;
  logic [CW-1:0] dst_cnt;
  logic [CW-1:0] remaining;
  logic          pending;
  logic          first;
  logic          sel;
  logic          accept;
  logic          has_room;

  assign accept    = (state == S_LOAD) && load_valid;
  assign has_room  = fill < CW'(CAPACITY);
  assign fill_next = has_room ? fill + CW'(1) : fill;
  assign issue_m1  = issue - CW'(1);
  assign busy      = (state != S_LOAD);

  always_comb begin
    cmd.load_wr  = accept && has_room;
    cmd.scan_rd  = (state == S_SCAN) && (issue != '0);
    cmd.proc     = pending;
    cmd.first    = first;
    cmd.load_out = (state == S_EMIT) && out_free;
    cmd.out_last = (remaining == CW'(1));
    cmd.sel      = sel;
  end

  assign wr_addr = (state == S_LOAD) ? fill[AW-1:0] : dst_cnt[AW-1:0];
  assign rd_addr = issue_m1[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      fill      <= '0;
      issue     <= '0;
      dst_cnt   <= '0;
      remaining <= '0;
      pending   <= 1'b0;
      first     <= 1'b0;
      sel       <= 1'b0;
    end else begin
      pending <= cmd.scan_rd;
      case (state)
        S_LOAD: begin
          if (accept) begin
            fill <= fill_next;
            if (load_last) begin
              issue     <= fill_next;
              remaining <= fill_next;
              dst_cnt   <= '0;
              first     <= 1'b1;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cmd.scan_rd) begin
            issue <= issue_m1;
          end
          // The first value of a pass only seeds the minimum; every later
          // one pushes a loser onto the other area.
          if (pending) begin
            if (first) begin
              first <= 1'b0;
            end else begin
              dst_cnt <= dst_cnt + CW'(1);
            end
          end
          if ((issue == '0) && !pending) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            remaining <= remaining - CW'(1);
            sel       <= !sel;
            issue     <= dst_cnt;
            dst_cnt   <= '0;
            first     <= 1'b1;
            if (remaining == CW'(1)) begin
              fill  <= '0;
              state <= S_LOAD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

[rtl/core/tss_dpath.sv]
// Datapath of the sorter: two stack areas, the running minimum and the output register.
// Depends on tss_pkg and tss_ram.
module tss_dpath import tss_pkg::*; #(
  parameter int CAPACITY = 64,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ctl_cmd_t                 cmd,
  input  logic [AW-1:0]            wr_addr,
  input  logic [AW-1:0]            rd_addr,
  input  logic signed [DATA_W-1:0] load_value,
  input  logic                     out_stall,
  output logic                     out_free,
  output logic                     out_valid,
  output sort_item_t               out_item
);

  logic [DATA_W-1:0]        rdata_a;
  logic [DATA_W-1:0]        rdata_b;
  logic [DATA_W-1:0]        wdata_a;
  logic [DATA_W-1:0]        wdata_b;
  logic                     we_a;
  logic                     we_b;
  logic                     re_a;
  logic                     re_b;
  logic                     dst_we;
  logic                     is_less;
  logic signed [DATA_W-1:0] src_rdata;
  logic signed [DATA_W-1:0] loser;
  logic signed [DATA_W-1:0] best;

  assign src_rdata = cmd.sel ? $signed(rdata_b) : $signed(rdata_a);
  assign is_less   = src_rdata < best;
  assign loser     = is_less ? best : src_rdata;
  assign dst_we    = cmd.proc && !cmd.first;

  // Loads go to the source area, scan losers to the other one.
  assign we_a    = cmd.sel ? dst_we : cmd.load_wr;
  assign we_b    = cmd.sel ? cmd.load_wr : dst_we;
  assign wdata_a = cmd.sel ? loser : load_value;
  assign wdata_b = cmd.sel ? load_value : loser;
  assign re_a    = cmd.scan_rd && !cmd.sel;
  assign re_b    = cmd.scan_rd && cmd.sel;

  tss_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (wr_addr),
    .wdata (wdata_a),
    .re    (re_a),
    .raddr (rd_addr),
    .rdata (rdata_a)
  );

  tss_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (wr_addr),
    .wdata (wdata_b),
    .re    (re_b),
    .raddr (rd_addr),
    .rdata (rdata_b)
  );

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.proc && (cmd.first || is_less)) begin
      best <= src_rdata;
    end
    if (cmd.load_out) begin
      out_item.sorted_value <= best;
      out_item.sorted_last  <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
